>>> hw/rtl/esld_pkg.sv
// Shared types, constants and month table for the epoch to local date converter.
package esld_pkg;

  // Configuration port
  localparam int unsigned PADDR_W      = 3;
  localparam logic        REG_ZONE_OFS = 1'b0;           // word index of the zone offset
  localparam logic [15:0] ZONE_OFS_RST = 16'd32400;      // nine hours

  // Pipeline depth from request to the final field registers, output register excluded
  localparam int unsigned PIPE_DEPTH = 7;

  // Seconds per day and its reciprocal: floor(x / 675) == (x * DAY_RECIP) >> 35, x < 2^25
  localparam logic [16:0] DAY_SECS  = 17'd86400;
  localparam logic [25:0] DAY_RECIP = 26'd50903317;

  // floor(x / 225) == (x * HOUR_RECIP) >> 21 for x < 5400
  localparam logic [11:0] HOUR_SECS  = 12'd3600;
  localparam logic [13:0] HOUR_RECIP = 14'd9321;

  // floor(x / 15) == (x * MIN_RECIP) >> 14 for x < 900
  localparam logic [5:0]  MIN_SECS  = 6'd60;
  localparam logic [10:0] MIN_RECIP = 11'd1093;

  // Four-year cycles counted from 1969-01-01, leap year last in each cycle
  localparam logic [8:0]  YEAR_DAYS  = 9'd365;
  localparam logic [10:0] QUAD_DAYS  = 11'd1461;
  localparam logic [15:0] QUAD_RECIP = 16'd45934;        // (x * QUAD_RECIP) >> 26, x < 2^15
  localparam logic [7:0]  QUAD_BASE  = 8'd69;            // 1969 - 1900

  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } tod_t;

  typedef struct packed {
    logic [7:0] year;
    logic [3:0] month;
    logic [4:0] mday;
    logic [8:0] yday;
    logic [2:0] wday;
  } date_t;

  // First day of year of each month, with February 29 counted in leap years
  function automatic logic [8:0] month_start(input logic [3:0] mon, input logic leap);
    logic [8:0] base;
    case (mon)
      4'd0:    base = 9'd0;
      4'd1:    base = 9'd31;
      4'd2:    base = 9'd59;
      4'd3:    base = 9'd90;
      4'd4:    base = 9'd120;
      4'd5:    base = 9'd151;
      4'd6:    base = 9'd181;
      4'd7:    base = 9'd212;
      4'd8:    base = 9'd243;
      4'd9:    base = 9'd273;
      4'd10:   base = 9'd304;
      4'd11:   base = 9'd334;
      default: base = 9'd0;
    endcase
    return base + {8'b0, leap && (mon >= 4'd2)};
  endfunction

endpackage

>>> hw/rtl/esld_cfg.sv
// APB register holding the time zone offset.
module esld_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [esld_pkg::PADDR_W-1:0]   paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  output logic [15:0]                    zone_ofs_o
);
  import esld_pkg::*;

  logic        wr_en;
  logic        sel_ofs;
  logic [15:0] ofs_q;
  logic [15:0] ofs_d;

  assign pready  = 1'b1;
  assign sel_ofs = (paddr[2] == REG_ZONE_OFS);
  assign wr_en   = psel && penable && pwrite && pready;

  // Offset register, write in the access phase
  always_comb begin
    ofs_d = ofs_q;
    if (wr_en && sel_ofs) begin
      ofs_d = pwdata[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ofs_q <= ZONE_OFS_RST;
    end else begin
      ofs_q <= ofs_d;
    end
  end

  // Read back
  assign prdata     = sel_ofs ? {16'b0, ofs_q} : 32'b0;
  assign zone_ofs_o = ofs_q;

endmodule

>>> hw/rtl/esld_daysplit.sv
// Offset add and split of local seconds into day count and seconds of day.
module esld_daysplit (
  input  logic        clk_i,
  input  logic [30:0] epoch_i,     // sign already peeled off
  input  logic [15:0] zone_ofs_i,
  output logic [14:0] days_o,
  output logic [16:0] secs_o
);
  import esld_pkg::*;

  logic [31:0] t_q, t_d;
  logic [49:0] prod_q, prod_d;
  logic [16:0] tlo_q;
  logic [14:0] days_w;
  logic [14:0] days_q;
  logic [16:0] secs_q, secs_d;

  // Stage 1: local seconds
  assign t_d = {1'b0, epoch_i} + {16'b0, zone_ofs_i};

  // Stage 2: t / 86400 as (t >> 7) / 675 by reciprocal
  assign prod_d = 50'(t_q[31:7]) * 50'(DAY_RECIP);

  // Stage 3: quotient and remainder, low 17 bits are enough for the remainder
  assign days_w = prod_q[49:35];
  assign secs_d = tlo_q - 17'({2'b0, days_w} * DAY_SECS);

  always_ff @(posedge clk_i) begin
    t_q    <= t_d;
    prod_q <= prod_d;
    tlo_q  <= t_q[16:0];
    days_q <= days_w;
    secs_q <= secs_d;
  end

  assign days_o = days_q;
  assign secs_o = secs_q;

endmodule

>>> hw/rtl/esld_clock.sv
// Seconds of day to hour, minute and second, four register stages.
module esld_clock (
  input  logic            clk_i,
  input  logic [16:0]     secs_i,
  output esld_pkg::tod_t  tod_o
);
  import esld_pkg::*;

  logic [25:0] hprod_q, hprod_d;
  logic [11:0] slo_q;
  logic [4:0]  hour_w;
  logic [4:0]  hour_q, hour2_q;
  logic [11:0] remh_q, remh_d, remh2_q;
  logic [19:0] mprod_q, mprod_d;
  logic [5:0]  min_w;
  logic [5:0]  sec_w;
  tod_t        tod_q, tod_d;

  // Hour by reciprocal of 225 on secs >> 4
  assign hprod_d = 26'(secs_i[16:4]) * 26'(HOUR_RECIP);

  // Remainder within the hour, below 3600
  assign hour_w = hprod_q[25:21];
  assign remh_d = slo_q - 12'({7'b0, hour_w} * HOUR_SECS);

  // Minute by reciprocal of 15 on rem >> 2
  assign mprod_d = 20'(remh_q[11:2]) * 20'(MIN_RECIP);

  // Minute and second
  assign min_w = mprod_q[19:14];
  assign sec_w = remh2_q[5:0] - 6'(min_w * MIN_SECS);

  always_comb begin
    tod_d.hour   = hour2_q;
    tod_d.minute = min_w;
    tod_d.second = sec_w;
  end

  always_ff @(posedge clk_i) begin
    hprod_q <= hprod_d;
    slo_q   <= secs_i[11:0];
    hour_q  <= hour_w;
    remh_q  <= remh_d;
    mprod_q <= mprod_d;
    hour2_q <= hour_q;
    remh2_q <= remh_q;
    tod_q   <= tod_d;
  end

  assign tod_o = tod_q;

endmodule

>>> hw/rtl/esld_calendar.sv
// Day count to year, month, day of month, day of year and weekday, four register stages.
module esld_calendar (
  input  logic             clk_i,
  input  logic [14:0]      days_i,
  output esld_pkg::date_t  date_o
);
  import esld_pkg::*;

  logic [14:0] d1_w, d1_q;
  logic [30:0] qprod_q, qprod_d;
  logic [14:0] wx_w;
  logic [5:0]  wsum1_w;
  logic [3:0]  wsum2_w;
  logic [2:0]  wday_d, wday_q, wday2_q, wday3_q;
  logic [4:0]  q4_w, q4_q;
  logic [10:0] r4_q, r4_d;
  logic [1:0]  yin_w;
  logic [8:0]  yday_d, yday_q;
  logic [7:0]  year_d, year_q;
  logic        leap_q;
  logic [3:0]  mon_w;
  logic [8:0]  mday_w;
  date_t       date_q, date_d;

  // Stage 1: days from 1969-01-01 and four-year cycle by reciprocal
  assign d1_w    = days_i + 15'(YEAR_DAYS);
  assign qprod_d = 31'(d1_w) * 31'(QUAD_RECIP);

  // Weekday: (days + 4) mod 7 by folding octal digits, since 8 = 1 mod 7
  assign wx_w    = days_i + 15'd4;
  assign wsum1_w = 6'(wx_w[2:0]) + 6'(wx_w[5:3]) + 6'(wx_w[8:6])
                 + 6'(wx_w[11:9]) + 6'(wx_w[14:12]);
  assign wsum2_w = 4'(wsum1_w[5:3]) + 4'(wsum1_w[2:0]);
  assign wday_d  = (wsum2_w >= 4'd7) ? 3'(wsum2_w - 4'd7) : wsum2_w[2:0];

  // Stage 2: cycle index and day within the cycle
  assign q4_w = qprod_q[30:26];
  assign r4_d = d1_q[10:0] - 11'({6'b0, q4_w} * QUAD_DAYS);

  // Stage 3: year within the cycle, the last one is the leap year
  assign yin_w = 2'(r4_q >= 11'd365) + 2'(r4_q >= 11'd730) + 2'(r4_q >= 11'd1095);

  always_comb begin
    case (yin_w)
      2'd0:    yday_d = 9'(r4_q);
      2'd1:    yday_d = 9'(r4_q - 11'd365);
      2'd2:    yday_d = 9'(r4_q - 11'd730);
      2'd3:    yday_d = 9'(r4_q - 11'd1095);
      default: yday_d = 9'(r4_q);
    endcase
  end

  assign year_d = QUAD_BASE + {1'b0, q4_q, 2'b00} + {6'b0, yin_w};

  // Stage 4: month from parallel compares against month starts
  always_comb begin
    mon_w = 4'd0;
    for (int m = 1; m < 12; m++) begin
      if (yday_q >= month_start(4'(m), leap_q)) begin
        mon_w = 4'(m);
      end
    end
  end

  assign mday_w = yday_q - month_start(mon_w, leap_q) + 9'd1;

  always_comb begin
    date_d.year  = year_q;
    date_d.month = mon_w;
    date_d.mday  = mday_w[4:0];
    date_d.yday  = yday_q;
    date_d.wday  = wday3_q;
  end

  always_ff @(posedge clk_i) begin
    d1_q    <= d1_w;
    qprod_q <= qprod_d;
    wday_q  <= wday_d;
    q4_q    <= q4_w;
    r4_q    <= r4_d;
    wday2_q <= wday_q;
    yday_q  <= yday_d;
    year_q  <= year_d;
    leap_q  <= (yin_w == 2'd3);
    wday3_q <= wday2_q;
    date_q  <= date_d;
  end

  assign date_o = date_q;

endmodule

>>> hw/rtl/epoch_seconds_to_local_date.sv
// Top level: epoch seconds to local calendar date, fully pipelined.
//
//   channel    | handshake             | payload
//   -----------+-----------------------+--------------------------------------------
//   request    | start, busy (always 0)| epoch_seconds_i
//   result     | done_o strobe         | valid_res_o, second_o .. year_day_o
//   config     | APB psel/penable      | paddr, pwdata, prdata (zone offset at 0x0)
//
// A request enters every cycle; its result strobes on done_o once it has passed the output register.
// The latency is set by the reciprocal multiply chains (day split, then hour/minute
// and four-year cycle), each multiplier followed by a register.
// Reset clears the valid line and sets the zone offset to nine hours.
// Nothing stalls: busy stays low and results are shown for one cycle only.
module epoch_seconds_to_local_date (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // request
  input  logic                          start,
  output logic                          busy,
  input  logic [31:0]                   epoch_seconds_i,
  // result
  output logic                          done_o,
  output logic                          valid_res_o,
  output logic [5:0]                    second_o,
  output logic [5:0]                    minute_o,
  output logic [4:0]                    hour_o,
  output logic [4:0]                    month_day_o,
  output logic [3:0]                    month_o,
  output logic [7:0]                    years_since_1900_o,
  output logic [2:0]                    weekday_o,
  output logic [8:0]                    year_day_o,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [esld_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import esld_pkg::*;

  logic                  accept;
  logic [15:0]           zone_ofs;
  logic [14:0]           days;
  logic [16:0]           secs;
  tod_t                  tod;
  date_t                 date;
  logic [PIPE_DEPTH-1:0] vld_q, vld_d;
  logic [PIPE_DEPTH-1:0] neg_q, neg_d;
  logic                  done_q;
  logic                  ok;
  tod_t                  tod_q, tod_d;
  date_t                 date_q, date_d;
  logic                  res_q;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  esld_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .zone_ofs_o (zone_ofs)
  );

  esld_daysplit u_daysplit (
    .clk_i      (clk_i),
    .epoch_i    (epoch_seconds_i[30:0]),
    .zone_ofs_i (zone_ofs),
    .days_o     (days),
    .secs_o     (secs)
  );

  esld_clock u_clock (
    .clk_i  (clk_i),
    .secs_i (secs),
    .tod_o  (tod)
  );

  esld_calendar u_calendar (
    .clk_i  (clk_i),
    .days_i (days),
    .date_o (date)
  );

  // Valid and sign bits travel alongside the datapath
  assign vld_d = {vld_q[PIPE_DEPTH-2:0], accept};
  assign neg_d = {neg_q[PIPE_DEPTH-2:0], epoch_seconds_i[31]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      done_q <= 1'b0;
    end else begin
      vld_q  <= vld_d;
      done_q <= vld_q[PIPE_DEPTH-1];
    end
  end

  // Output register, negative requests give all-zero fields
  assign ok     = !neg_q[PIPE_DEPTH-1];
  assign tod_d  = ok ? tod  : '0;
  assign date_d = ok ? date : '0;

  always_ff @(posedge clk_i) begin
    neg_q  <= neg_d;
    res_q  <= ok;
    tod_q  <= tod_d;
    date_q <= date_d;
  end

  assign done_o             = done_q;
  assign valid_res_o        = res_q;
  assign second_o           = tod_q.second;
  assign minute_o           = tod_q.minute;
  assign hour_o             = tod_q.hour;
  assign month_day_o        = date_q.mday;
  assign month_o            = date_q.month;
  assign years_since_1900_o = date_q.year;
  assign weekday_o          = date_q.wday;
  assign year_day_o         = date_q.yday;

  // Every result traces back to an accepted request, through the valid pipeline and the done register
  a_done_from_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, PIPE_DEPTH + 1))
    else $error("result without matching request");

  // Error flag follows the sign of that request
  a_sign_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (valid_res_o == !$past(epoch_seconds_i[31], PIPE_DEPTH + 1)))
    else $error("valid_res does not match request sign");

  // Time of day in range on converted results
  a_tod_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && valid_res_o) |-> (second_o < 6'd60 && minute_o < 6'd60 && hour_o < 5'd24))
    else $error("time of day out of range");

  // Calendar fields in range on converted results
  a_date_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && valid_res_o) |-> (month_o < 4'd12 && month_day_o != 5'd0 &&
                                 weekday_o < 3'd7 && year_day_o < 9'd366 + 9'(1'b0) + 9'd0 + 9'd0 ||
                                 (year_day_o == 9'd365 && month_o == 4'd11)))
    else $error("date field out of range");

  // Error results carry zero fields
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !valid_res_o) |-> (years_since_1900_o == 8'd0 && year_day_o == 9'd0))
    else $error("error result has nonzero fields");

endmodule
